// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker module of the core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Types, codes and widths shared by the TLB lookup/insert block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tli_pkg;

    // Field widths of the stream words.
    localparam int OPCODE_W   = 3;
    localparam int PAGE_W     = 8;
    localparam int ACCESS_W   = 2;
    localparam int FRAME_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = OPCODE_W;
    localparam int M_TDATA_W  = 16;

    // Bit positions in the input and output words.
    localparam int S_PAGE_LSB   = 0;
    localparam int S_ACCESS_LSB = S_PAGE_LSB + PAGE_W;
    localparam int S_FRAME_LSB  = S_ACCESS_LSB + ACCESS_W;
    localparam int M_HIT_BIT    = 0;
    localparam int M_FRAME_LSB  = 1;
    localparam int M_STATUS_LSB = M_FRAME_LSB + FRAME_W;
    localparam int M_PAD_W      = M_TDATA_W - (M_STATUS_LSB + STATUS_W);

    // Default geometry of the table.
    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_PAGE_BITS  = 8;
    localparam int DEF_FRAME_BITS = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOOKUP     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_INVALIDATE = 3'd2,
        OP_FLUSH      = 3'd3,
        OP_SET_PERM   = 3'd4,
        OP_SET_FRAME  = 3'd5
    } op_t;

    localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_COMPARE = 3'b010,
        S_UPDATE  = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/tli_dp.sv
// ----------------------------------------------------------------------------
// tli_dp
// Entry array, parallel compare vectors, slot selection and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tli_dp #(
    parameter int ENTRIES    = tli_pkg::DEF_ENTRIES,
    parameter int PAGE_BITS  = tli_pkg::DEF_PAGE_BITS,
    parameter int FRAME_BITS = tli_pkg::DEF_FRAME_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tli_pkg::cmd_t                cmd,
    output tli_pkg::sts_t                sts,
    input  logic [tli_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [tli_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tli_pkg::M_TDATA_W-1:0] m_tdata
);

    // Request held for the compare and update cycles.
    tli_pkg::op_t                  op_reg;
    logic [PAGE_BITS-1:0]          page_reg;
    logic [tli_pkg::ACCESS_W-1:0]  acc_reg;
    logic [FRAME_BITS-1:0]         frame_reg;

    // Table contents.
    logic [ENTRIES-1:0]            valid_reg;
    logic [ENTRIES-1:0]            valid_next;
    logic [PAGE_BITS-1:0]          page_tab_reg  [ENTRIES];
    logic [tli_pkg::ACCESS_W-1:0]  acc_tab_reg   [ENTRIES];
    logic [FRAME_BITS-1:0]         frame_tab_reg [ENTRIES];

    // Compare vectors, registered at the end of the compare cycle.
    logic [ENTRIES-1:0]            match_reg;
    logic [ENTRIES-1:0]            perm_reg;
    logic [ENTRIES-1:0]            free_reg;

    logic [ENTRIES-1:0]            match_first;
    logic [ENTRIES-1:0]            perm_first;
    logic [ENTRIES-1:0]            free_first;
    logic [ENTRIES-1:0]            ins_sel;
    logic                          any_match;
    logic                          any_perm;
    logic                          any_free;
    logic                          ins_ok;
    logic [FRAME_BITS-1:0]         frame_sel;

    logic [31:0]                   page_wide;
    logic [31:0]                   frame_wide;
    logic [31:0]                   fsel_wide;

    logic                          res_hit;
    logic [tli_pkg::FRAME_W-1:0]   res_frame;
    logic [tli_pkg::STATUS_W-1:0]  res_status;

    logic                          out_valid_reg;
    logic [tli_pkg::M_TDATA_W-1:0] out_data_reg;

    // Fields are resized to the configured table widths.
    assign page_wide  = {{(32 - tli_pkg::PAGE_W){1'b0}},
                         s_tdata[tli_pkg::S_PAGE_LSB +: tli_pkg::PAGE_W]};
    assign frame_wide = {{(32 - tli_pkg::FRAME_W){1'b0}},
                         s_tdata[tli_pkg::S_FRAME_LSB +: tli_pkg::FRAME_W]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= tli_pkg::op_t'(s_tuser);
            page_reg  <= page_wide[PAGE_BITS-1:0];
            acc_reg   <= s_tdata[tli_pkg::S_ACCESS_LSB +: tli_pkg::ACCESS_W];
            frame_reg <= frame_wide[FRAME_BITS-1:0];
        end
    end

    // One comparator per entry.
    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                match_reg[i] <= valid_reg[i] && (page_tab_reg[i] == page_reg);
                perm_reg[i]  <= valid_reg[i] && (page_tab_reg[i] == page_reg) &&
                                ((acc_tab_reg[i] & acc_reg) == acc_reg);
                free_reg[i]  <= !valid_reg[i];
            end
        end
    end

    // Lowest set bit of each vector, isolated with a two's complement.
    assign match_first = match_reg & (~match_reg + ENTRIES'(1));
    assign perm_first  = perm_reg  & (~perm_reg  + ENTRIES'(1));
    assign free_first  = free_reg  & (~free_reg  + ENTRIES'(1));
    assign any_match   = |match_reg;
    assign any_perm    = |perm_reg;
    assign any_free    = |free_reg;
    assign ins_sel     = any_match ? match_first : free_first;
    assign ins_ok      = any_match || any_free;

    always_comb
    begin
        frame_sel = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            frame_sel = frame_sel | (perm_first[i] ? frame_tab_reg[i] : '0);
        end
    end

    assign fsel_wide = {{(32 - FRAME_BITS){1'b0}}, frame_sel};

    always_comb
    begin
        res_hit    = 1'b0;
        res_frame  = '0;
        res_status = tli_pkg::STAT_DONE;
        valid_next = valid_reg;
        case (op_reg)
            tli_pkg::OP_LOOKUP:
            begin
                res_hit    = any_perm;
                res_frame  = any_perm ? fsel_wide[tli_pkg::FRAME_W-1:0] : '0;
                res_status = any_perm ? tli_pkg::STAT_DONE : tli_pkg::STAT_MISS;
            end
            tli_pkg::OP_INSERT:
            begin
                res_status = ins_ok ? tli_pkg::STAT_DONE : tli_pkg::STAT_FULL;
                valid_next = valid_reg | ins_sel;
            end
            tli_pkg::OP_INVALIDATE:
            begin
                res_status = any_match ? tli_pkg::STAT_DONE : tli_pkg::STAT_MISS;
                valid_next = valid_reg & ~match_reg;
            end
            tli_pkg::OP_FLUSH:
            begin
                valid_next = '0;
            end
            tli_pkg::OP_SET_PERM, tli_pkg::OP_SET_FRAME:
            begin
                res_status = any_match ? tli_pkg::STAT_DONE : tli_pkg::STAT_MISS;
            end
            default:
            begin
                res_status = tli_pkg::STAT_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload; an insert writes one slot, the set operations every match.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (op_reg == tli_pkg::OP_INSERT && ins_sel[i])
                begin
                    page_tab_reg[i]  <= page_reg;
                    acc_tab_reg[i]   <= acc_reg;
                    frame_tab_reg[i] <= frame_reg;
                end
                if (op_reg == tli_pkg::OP_SET_PERM && match_reg[i])
                begin
                    acc_tab_reg[i] <= acc_reg;
                end
                if (op_reg == tli_pkg::OP_SET_FRAME && match_reg[i])
                begin
                    frame_tab_reg[i] <= frame_reg;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= {{tli_pkg::M_PAD_W{1'b0}}, res_status, res_frame, res_hit};
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

endmodule

// File: rtl/core/tli_ctrl.sv
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer that steps each request through compare and update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tli_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output tli_pkg::cmd_t cmd,
    input  tli_pkg::sts_t sts
);

    tli_pkg::state_t state_reg;
    tli_pkg::state_t state_next;

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.compare = 1'b0;
        cmd.commit  = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            tli_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
            end
            tli_pkg::S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = tli_pkg::S_UPDATE;
            end
            tli_pkg::S_UPDATE:
            begin
                // The update finishes only when the result register can take it.
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    s_tready   = 1'b1;
                    state_next = tli_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tli_pkg::S_IDLE;
            end
        endcase
        cmd.load = s_tvalid && s_tready;
        if (cmd.load)
        begin
            state_next = tli_pkg::S_COMPARE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tli_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/tlb_lookup_insert.sv
// ----------------------------------------------------------------------------
// tlb_lookup_insert
// Fully associative TLB with lookup, insert and maintenance operations.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Word contents (lowest bit first)
// s_*      in   tuser: opcode[2:0]
//                tdata: page_number[7:0], access_bits[9:8], frame_number[16:10]
// m_*      out  tdata: hit[0], frame_out[7:1], status[9:8]
//
// Every request produces exactly one result word.
// A request passes through a compare state, in which every entry compares its page
// and permissions in parallel, and an update state that picks the lowest matching or
// free slot, writes the table and loads the result register.
// The next request is taken in that update state, so the block accepts a new word
// before the current result has left, as long as the output is drained.
// A result that waits on m_tready holds the update cycle and with it s_tready.
// After reset all entries are invalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlb_lookup_insert #(
    parameter int ENTRIES    = tli_pkg::DEF_ENTRIES,
    parameter int PAGE_BITS  = tli_pkg::DEF_PAGE_BITS,
    parameter int FRAME_BITS = tli_pkg::DEF_FRAME_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // page_number[7:0], access_bits[9:8], frame_number[16:10], zero pad
    input  logic [tli_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[2:0]
    input  logic [tli_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit[0], frame_out[7:1], status[9:8], zero pad
    output logic [tli_pkg::M_TDATA_W-1:0] m_tdata
);

    // Command and status between the sequencer and the datapath.
    tli_pkg::cmd_t cmd;
    tli_pkg::sts_t sts;

    tli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tli_dp #(
        .ENTRIES    (ENTRIES),
        .PAGE_BITS  (PAGE_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/core/tli_checker.sv
// ----------------------------------------------------------------------------
// tli_checker
// Port-level checks of the TLB block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tli_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tli_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                         hit;
    logic [tli_pkg::FRAME_W-1:0]  frame;
    logic [tli_pkg::STATUS_W-1:0] status;
    logic                         status_ok;

    assign hit    = m_tdata[tli_pkg::M_HIT_BIT];
    assign frame  = m_tdata[tli_pkg::M_FRAME_LSB +: tli_pkg::FRAME_W];
    assign status = m_tdata[tli_pkg::M_STATUS_LSB +: tli_pkg::STATUS_W];

    assign status_ok = (status == tli_pkg::STAT_DONE) ||
                       (status == tli_pkg::STAT_MISS) ||
                       (status == tli_pkg::STAT_FULL);

    // A stalled result word stays put.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A hit always reports a completed operation.
    `ASSERT_SAME(a_hit_done, clk, rst_n, m_tvalid && hit, status == tli_pkg::STAT_DONE)

    // Without a hit the frame field is cleared.
    `ASSERT_SAME(a_miss_frame, clk, rst_n, m_tvalid && !hit, frame == '0)

    // Only the three defined status codes appear.
    `ASSERT_SAME(a_status_code, clk, rst_n, m_tvalid, status_ok)

    // Each request owns the compare cycle, so no word is taken right after one.
    `ASSERT_NEXT(a_compare_gap, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind tlb_lookup_insert tli_checker u_tli_checker (.*);
